// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker module of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also watches the reset cycles themselves.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/fppud_pkg.sv =====
// ----------------------------------------------------------------------------
// fppud_pkg
// Types and codes shared by the form pair parser with URL decoding.
// ----------------------------------------------------------------------------
package fppud_pkg;

    // Result beat slots in one command; one input byte causes at most five.
    localparam int MAX_RES = 6;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_KEY        = 3'd0,
        KIND_VALUE      = 3'd1,
        KIND_PAIR_END   = 3'd2,
        KIND_ERROR      = 3'd3,
        KIND_RECORD_END = 3'd4
    } t_kind;

    // Error codes carried with an error beat.
    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_SEP_IN_KEY  = 2'd1,
        ERR_EQ_IN_VALUE = 2'd2,
        ERR_UNTERM_KEY  = 2'd3
    } t_err;

    // One result beat.
    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        t_err       code;
    } t_item;

    // Count and index of beats within one command.
    typedef logic [2:0] t_cnt;

    // Everything one input byte produces, in emit order from index 0.
    typedef struct packed {
        t_cnt                  count;
        t_item [MAX_RES-1:0]   items;
    } t_cmd;

endpackage

// ===== src/fppud_if.sv =====
// ----------------------------------------------------------------------------
// fppud_if
// Valid/ready channels for raw input bytes and for parsed result beats.
// ----------------------------------------------------------------------------
interface fppud_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface fppud_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic [1:0] error_code;
    logic       run_last;

    modport source (
        output valid, output out_byte, output kind, output error_code,
        output run_last, input ready
    );
    modport sink (
        input valid, input out_byte, input kind, input error_code,
        input run_last, output ready
    );
endinterface

// ===== src/form_pair_parser_url_decode_core.sv =====
// ----------------------------------------------------------------------------
// form_pair_parser_url_decode_core
// Streaming key=value record parser that URL-decodes value bytes.
// ----------------------------------------------------------------------------
// Usage:
// i_in carries one raw record byte per beat with in_last on the final byte.
// o_out carries result beats: key bytes, decoded value bytes, pair ends,
// errors and record ends, with run_last set on the final beat of each byte.
// One input byte causes zero to five result beats.
// The pair separator is written through i_cfg_wr_en and i_cfg_wr_data; the user
// writes it while the block is idle, which the block itself does not enforce; it resets to the ampersand.
// The first result beat of a byte passes through the command queue and then
// the registered output stage. The parsing front takes one byte per cycle
// while the queue is not full; the back end sends one result beat per cycle
// while the receiver is ready, so a byte with several results holds the back
// end until its last beat is sent while the command queue of DEPTH entries
// absorbs later bytes.
// Reset is synchronous and clears the parse state, the queue and the output
// valid, and restores the separator. When the receiver stalls, the output
// beat holds and the queue fills; i_in.ready drops once the queue is full.
// ----------------------------------------------------------------------------
module form_pair_parser_url_decode_core #(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    fppud_in_if.sink    i_in,
    fppud_out_if.source o_out
);

    logic            push;
    fppud_pkg::t_cmd push_cmd;
    logic            q_full;
    logic            q_valid;
    fppud_pkg::t_cmd q_head;
    logic            pop;

    // Byte classification and parse state.
    fppud_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_push_cmd    (push_cmd)
    );

    // Command queue between the two halves.
    fppud_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_head     (q_head),
        .i_pop      (pop)
    );

    // Result beat sequencing.
    fppud_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ===== src/fppud_front.sv =====
// ----------------------------------------------------------------------------
// fppud_front
// Accepts one raw byte per beat, runs the parse state and turns the byte into
// a command that lists every result beat it causes.
// ----------------------------------------------------------------------------
module fppud_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    fppud_in_if.sink           i_in,
    input  logic               i_q_full,
    output logic               o_push,
    output fppud_pkg::t_cmd    o_push_cmd
);

    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_VALUE = 2'd1,
        MODE_DROP  = 2'd2
    } t_mode;

    // Working copy of the parse state plus the beats collected so far.
    typedef struct packed {
        t_mode           mode;
        logic [1:0]      held;
        logic [7:0]      digit;
        logic            key_started;
        logic            val_trunc;
        fppud_pkg::t_cmd cmd;
    } t_ctx;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] SEP_RST  = 8'd38;

    logic [7:0] r_sep;
    t_mode      r_mode;
    logic [1:0] r_held;
    logic [7:0] r_digit;
    logic       r_key_started;
    logic       r_val_trunc;
    t_ctx       n_ctx;
    logic       accept;

    function automatic t_ctx f_emit(t_ctx x, logic [7:0] b, fppud_pkg::t_kind k,
                                    fppud_pkg::t_err e);
        t_ctx y;
        y = x;
        y.cmd.items[y.cmd.count] = '{data: b, kind: k, code: e};
        y.cmd.count = y.cmd.count + 3'd1;
        return y;
    endfunction

    function automatic logic f_is_hex(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] f_hex_val(logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h61) begin
            v = c - 8'h57;
        end else if (c >= 8'h41) begin
            v = c - 8'h37;
        end else begin
            v = c - 8'h30;
        end
        return v[3:0];
    endfunction

    // A held escape that did not complete goes out as raw value bytes.
    function automatic t_ctx f_flush(t_ctx x);
        t_ctx y;
        y = x;
        if (y.held >= 2'd1) begin
            y = f_emit(y, CH_PCT, fppud_pkg::KIND_VALUE, fppud_pkg::ERR_NONE);
        end
        if (y.held >= 2'd2) begin
            y = f_emit(y, y.digit, fppud_pkg::KIND_VALUE, fppud_pkg::ERR_NONE);
        end
        y.held = 2'd0;
        return y;
    endfunction

    function automatic t_ctx f_plain(t_ctx x, logic [7:0] c);
        t_ctx y;
        y = x;
        if (c == 8'h00) begin
            y.val_trunc = 1'b1;
        end else if (c == CH_PCT) begin
            y.held = 2'd1;
        end else if (c == CH_PLUS) begin
            y = f_emit(y, CH_SPACE, fppud_pkg::KIND_VALUE, fppud_pkg::ERR_NONE);
        end else begin
            y = f_emit(y, c, fppud_pkg::KIND_VALUE, fppud_pkg::ERR_NONE);
        end
        return y;
    endfunction

    function automatic t_ctx f_decode(t_ctx x, logic [7:0] c);
        t_ctx       y;
        logic [7:0] v;
        y = x;
        v = {f_hex_val(x.digit), f_hex_val(c)};
        if (y.val_trunc) begin
            y.held = 2'd0;
        end else if (y.held == 2'd0) begin
            y = f_plain(y, c);
        end else if (y.held == 2'd1) begin
            if (f_is_hex(c)) begin
                y.digit = c;
                y.held  = 2'd2;
            end else begin
                y = f_plain(f_flush(y), c);
            end
        end else begin
            if (f_is_hex(c)) begin
                y.held = 2'd0;
                if (v == 8'h00) begin
                    y.val_trunc = 1'b1;
                end else begin
                    y = f_emit(y, v, fppud_pkg::KIND_VALUE, fppud_pkg::ERR_NONE);
                end
            end else begin
                y = f_plain(f_flush(y), c);
            end
        end
        return y;
    endfunction

    function automatic t_ctx f_end_pair(t_ctx x);
        t_ctx y;
        y = f_flush(x);
        y = f_emit(y, 8'h00, fppud_pkg::KIND_PAIR_END, fppud_pkg::ERR_NONE);
        y.val_trunc   = 1'b0;
        y.key_started = 1'b0;
        return y;
    endfunction

    function automatic t_ctx f_end_record(t_ctx x);
        t_ctx y;
        y = x;
        if (y.mode == MODE_VALUE) begin
            y = f_end_pair(y);
        end else if (y.mode == MODE_KEY && y.key_started) begin
            y = f_emit(y, 8'h00, fppud_pkg::KIND_ERROR, fppud_pkg::ERR_UNTERM_KEY);
        end
        y = f_emit(y, 8'h00, fppud_pkg::KIND_RECORD_END, fppud_pkg::ERR_NONE);
        y.mode        = MODE_KEY;
        y.held        = 2'd0;
        y.digit       = 8'h00;
        y.key_started = 1'b0;
        y.val_trunc   = 1'b0;
        return y;
    endfunction

    // Classify the byte against the current state and collect its beats.
    always_comb begin
        logic [7:0] c;
        logic       ended;
        c     = i_in.in_byte;
        ended = 1'b0;
        n_ctx = '{mode: r_mode, held: r_held, digit: r_digit,
                  key_started: r_key_started, val_trunc: r_val_trunc, cmd: '0};
        if (c == CH_LF) begin
            n_ctx = f_end_record(n_ctx);
            ended = 1'b1;
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF ||
                     c == CH_CR) begin
            n_ctx = n_ctx;
        end else if (n_ctx.mode == MODE_KEY) begin
            if (c == CH_EQ) begin
                n_ctx.mode      = MODE_VALUE;
                n_ctx.held      = 2'd0;
                n_ctx.val_trunc = 1'b0;
            end else if (c == r_sep) begin
                n_ctx = f_emit(n_ctx, 8'h00, fppud_pkg::KIND_ERROR,
                               fppud_pkg::ERR_SEP_IN_KEY);
                n_ctx.mode = MODE_DROP;
            end else begin
                n_ctx = f_emit(n_ctx, c, fppud_pkg::KIND_KEY, fppud_pkg::ERR_NONE);
                n_ctx.key_started = 1'b1;
            end
        end else if (n_ctx.mode == MODE_VALUE) begin
            if (c == r_sep) begin
                n_ctx      = f_end_pair(n_ctx);
                n_ctx.mode = MODE_KEY;
            end else if (c == CH_EQ) begin
                n_ctx = f_emit(n_ctx, 8'h00, fppud_pkg::KIND_ERROR,
                               fppud_pkg::ERR_EQ_IN_VALUE);
                n_ctx.mode = MODE_DROP;
                n_ctx.held = 2'd0;
            end else begin
                n_ctx = f_decode(n_ctx, c);
            end
        end
        if (i_in.in_last && !ended) begin
            n_ctx = f_end_record(n_ctx);
        end
    end

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign o_push     = accept && (n_ctx.cmd.count != 3'd0);
    assign o_push_cmd = n_ctx.cmd;

    // Configuration register and parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep         <= SEP_RST;
            r_mode        <= MODE_KEY;
            r_held        <= 2'd0;
            r_digit       <= 8'h00;
            r_key_started <= 1'b0;
            r_val_trunc   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sep <= i_cfg_wr_data;
            end
            if (accept) begin
                r_mode        <= n_ctx.mode;
                r_held        <= n_ctx.held;
                r_digit       <= n_ctx.digit;
                r_key_started <= n_ctx.key_started;
                r_val_trunc   <= n_ctx.val_trunc;
            end
        end
    end

endmodule

// ===== src/fppud_queue.sv =====
// ----------------------------------------------------------------------------
// fppud_queue
// Short FIFO of commands between the parsing front and the emitting back.
// ----------------------------------------------------------------------------
module fppud_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fppud_pkg::t_cmd    i_push_cmd,
    output logic               o_full,
    output logic               o_valid,
    output fppud_pkg::t_cmd    o_head,
    input  logic               i_pop
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    fppud_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== src/fppud_back.sv =====
// ----------------------------------------------------------------------------
// fppud_back
// Walks the head command's beats one per cycle into a registered output stage
// unless the receiver stalls, and releases the command after its last beat.
// ----------------------------------------------------------------------------
module fppud_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  fppud_pkg::t_cmd    i_q_head,
    output logic               o_pop,
    fppud_out_if.source        o_out
);

    fppud_pkg::t_cnt r_idx;
    logic            r_valid;
    fppud_pkg::t_item r_item;
    logic            r_last;
    logic            load;
    logic            last_beat;

    assign load      = !r_valid || o_out.ready;
    assign last_beat = (r_idx == i_q_head.count - 3'd1);
    assign o_pop     = load && i_q_valid && last_beat;

    // Beat index and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_idx <= last_beat ? '0 : r_idx + 3'd1;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_item <= i_q_head.items[r_idx];
            r_last <= last_beat;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_item.data;
    assign o_out.kind       = r_item.kind;
    assign o_out.error_code = r_item.code;
    assign o_out.run_last   = r_last;

endmodule

// ===== src/fppud_checker.sv =====
// ----------------------------------------------------------------------------
// fppud_checker
// Port-level checks on the result channel of the form pair parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fppud_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [2:0] i_kind,
    input logic [1:0] i_error_code,
    input logic       i_run_last
);

    // A stalled beat keeps its valid and its payload.
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_out_byte, i_kind, i_error_code, i_run_last}), "stalled beat changed")

    // Only error beats carry an error code.
    `ASSERT_CLK(a_code, i_clk, i_rst_n, i_out_valid && i_kind != fppud_pkg::KIND_ERROR |-> i_error_code == fppud_pkg::ERR_NONE, "error code on a non-error beat")

    // Marker beats carry a zero byte.
    `ASSERT_CLK(a_marker, i_clk, i_rst_n, i_out_valid && (i_kind == fppud_pkg::KIND_PAIR_END || i_kind == fppud_pkg::KIND_ERROR || i_kind == fppud_pkg::KIND_RECORD_END) |-> i_out_byte == 8'h00, "marker beat with nonzero byte")

    // A record end is always the final beat of its input byte.
    `ASSERT_CLK(a_rec_last, i_clk, i_rst_n, i_out_valid && i_kind == fppud_pkg::KIND_RECORD_END |-> i_run_last, "record end not last beat")

    // Reset empties the output stage.
    `ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

endmodule

bind form_pair_parser_url_decode_core fppud_checker u_fppud_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_kind       (o_out.kind),
    .i_error_code (o_out.error_code),
    .i_run_last   (o_out.run_last)
);
